// File: hw/rtl/tvef_pkg.sv
// Shared types and character constants for the visible-escape text filter.
package tvef_pkg;

    typedef enum logic [2:0] {
        CFG_NUMBER_LINES   = 3'd0,
        CFG_NONBLANK_ONLY  = 3'd1,
        CFG_SHOW_ENDS      = 3'd2,
        CFG_SQUEEZE_BLANK  = 3'd3,
        CFG_SHOW_TABS      = 3'd4,
        CFG_SHOW_NONPRINT  = 3'd5
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;

    typedef struct packed {
        logic number_lines;
        logic number_nonblank_only;
        logic show_ends;
        logic squeeze_blank;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    typedef enum logic [1:0] {
        PFX_NONE   = 2'd0,
        PFX_NUMBER = 2'd1,
        PFX_PAD    = 2'd2
    } prefix_t;

    // One decoded input word: optional line prefix plus up to four body bytes.
    typedef struct packed {
        prefix_t         prefix;
        logic [3:0][7:0] body;
        logic [2:0]      body_len;
    } desc_t;

    typedef struct packed {
        logic busy;
        logic step_last;
    } emit_stat_t;

    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [6:0] CH_DEL     = 7'h7F;
    localparam logic [7:0] CH_HIGH_NL = 8'h8A;
    localparam logic [6:0] CARET_BIAS = 7'h40;
    localparam logic [6:0] CTRL_LIMIT = 7'h20;
    localparam logic [3:0] DIGIT_HI   = 4'h3;

endpackage

// File: hw/rtl/tvef_if.sv
// Valid/ready channel interfaces for input bytes and output characters.
interface tvef_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_start;

    modport source (output valid, output data_byte, output file_start, input ready);
    modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface tvef_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: hw/rtl/tvef_decode.sv
// Line state, BCD line counter and per-word decode into an output descriptor.
module tvef_decode #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tvef_pkg::cfg_t             cfg,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic                       file_start,
    output tvef_pkg::desc_t            desc,
    output logic [4*NUMBER_DIGITS-1:0] number,
    output logic                       emits
);

    localparam int NUM_W = 4 * NUMBER_DIGITS;

    logic             at_line_start_reg, at_line_start_next;
    logic             blank_squeezed_reg, blank_squeezed_next;
    logic [NUM_W-1:0] line_number_reg, line_number_next;

    logic             cur_start;
    logic             cur_squeezed;
    logic [NUM_W-1:0] cur_number;
    logic [NUM_W-1:0] inc_number;
    logic             is_nl;
    logic             is_tab;
    logic             is_high;
    logic [6:0]       low7;
    logic             is_ctrl;
    logic [7:0]       caret_char;

    // file_start clears the line state ahead of this word
    assign cur_start    = file_start | at_line_start_reg;
    assign cur_squeezed = ~file_start & blank_squeezed_reg;
    assign cur_number   = file_start ? '0 : line_number_reg;

    // Saturating BCD increment: a digit steps when every lower digit is nine
    always_comb
    begin
        logic all_nines;
        logic carry;
        all_nines = 1'b1;
        carry     = 1'b1;
        inc_number = cur_number;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (cur_number[4*i +: 4] != 4'd9)
                all_nines = 1'b0;
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry)
            begin
                if (cur_number[4*i +: 4] >= 4'd9)
                    inc_number[4*i +: 4] = 4'd0;
                else
                begin
                    inc_number[4*i +: 4] = cur_number[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nines)
            inc_number = cur_number;
    end

    assign is_nl      = (data_byte == tvef_pkg::CH_NL);
    assign is_tab     = (data_byte == tvef_pkg::CH_TAB);
    assign is_high    = data_byte[7];
    assign low7       = data_byte[6:0];
    assign is_ctrl    = (low7 < tvef_pkg::CTRL_LIMIT) || (low7 == tvef_pkg::CH_DEL);
    assign caret_char = (low7 == tvef_pkg::CH_DEL) ? tvef_pkg::CH_QMARK
                                                   : {1'b0, low7 | tvef_pkg::CARET_BIAS};

    always_comb
    begin
        desc                = '0;
        desc.prefix         = tvef_pkg::PFX_NONE;
        emits               = 1'b1;
        at_line_start_next  = at_line_start_reg;
        blank_squeezed_next = blank_squeezed_reg;
        line_number_next    = line_number_reg;
        number              = cur_number;

        if (cur_start && is_nl && cfg.squeeze_blank)
        begin
            // first blank line of a run passes as a bare newline, drop the rest
            desc.body[0]        = tvef_pkg::CH_NL;
            desc.body_len       = 3'd1;
            emits               = ~cur_squeezed;
            at_line_start_next  = 1'b1;
            blank_squeezed_next = 1'b1;
            line_number_next    = cur_number;
        end
        else
        begin
            if (cur_start && cfg.number_lines)
            begin
                if (!is_nl || !cfg.number_nonblank_only)
                    desc.prefix = tvef_pkg::PFX_NUMBER;
                else if (cfg.show_ends)
                    desc.prefix = tvef_pkg::PFX_PAD;
            end
            if (desc.prefix == tvef_pkg::PFX_NUMBER)
                number = inc_number;

            if (is_nl)
            begin
                if (cfg.show_ends)
                begin
                    desc.body[0]  = tvef_pkg::CH_DOLLAR;
                    desc.body[1]  = tvef_pkg::CH_NL;
                    desc.body_len = 3'd2;
                end
                else
                begin
                    desc.body[0]  = tvef_pkg::CH_NL;
                    desc.body_len = 3'd1;
                end
            end
            else if (is_tab)
            begin
                if (cfg.show_tabs)
                begin
                    desc.body[0]  = tvef_pkg::CH_CARET;
                    desc.body[1]  = tvef_pkg::CH_I;
                    desc.body_len = 3'd2;
                end
                else
                begin
                    desc.body[0]  = data_byte;
                    desc.body_len = 3'd1;
                end
            end
            else if (cfg.show_nonprinting)
            begin
                if (is_high && is_ctrl)
                begin
                    desc.body[0]  = tvef_pkg::CH_M;
                    desc.body[1]  = tvef_pkg::CH_DASH;
                    desc.body[2]  = tvef_pkg::CH_CARET;
                    desc.body[3]  = caret_char;
                    desc.body_len = 3'd4;
                end
                else if (is_high)
                begin
                    desc.body[0]  = tvef_pkg::CH_M;
                    desc.body[1]  = tvef_pkg::CH_DASH;
                    desc.body[2]  = {1'b0, low7};
                    desc.body_len = 3'd3;
                end
                else if (is_ctrl)
                begin
                    desc.body[0]  = tvef_pkg::CH_CARET;
                    desc.body[1]  = caret_char;
                    desc.body_len = 3'd2;
                end
                else
                begin
                    desc.body[0]  = data_byte;
                    desc.body_len = 3'd1;
                end
            end
            else
            begin
                desc.body[0]  = data_byte;
                desc.body_len = 3'd1;
            end

            // a high newline shown as M-^J still ends the line
            at_line_start_next  = is_nl ||
                                  (cfg.show_nonprinting && data_byte == tvef_pkg::CH_HIGH_NL);
            blank_squeezed_next = 1'b0;
            line_number_next    = number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg  <= 1'b1;
            blank_squeezed_reg <= 1'b0;
            line_number_reg    <= '0;
        end
        else if (accept)
        begin
            at_line_start_reg  <= at_line_start_next;
            blank_squeezed_reg <= blank_squeezed_next;
            line_number_reg    <= line_number_next;
        end
    end

endmodule

// File: hw/rtl/tvef_emit.sv
// Descriptor register and byte sequencer feeding the output register.
module tvef_emit #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  tvef_pkg::desc_t            desc,
    input  logic [4*NUMBER_DIGITS-1:0] number,
    output logic                       desc_free,
    output tvef_pkg::emit_stat_t       stat,
    tvef_out_if.source                 dout
);

    localparam int NUM_W = 4 * NUMBER_DIGITS;
    localparam int CNT_W = $clog2(NUMBER_DIGITS + 6);

    logic            desc_valid_reg, desc_valid_next;
    tvef_pkg::desc_t desc_reg;
    logic [NUM_W-1:0] number_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;

    logic [CNT_W-1:0] pfx_len;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] body_idx;
    logic             is_last;
    logic             step;
    logic [7:0]       cur_byte;
    logic [NUMBER_DIGITS-1:0] zero_above;

    assign pfx_len  = (desc_reg.prefix == tvef_pkg::PFX_NONE) ? '0 : CNT_W'(NUMBER_DIGITS + 1);
    assign total    = pfx_len + CNT_W'(desc_reg.body_len);
    assign body_idx = idx_reg - pfx_len;
    assign is_last  = (idx_reg == total - CNT_W'(1));
    assign step     = desc_valid_reg && (!out_valid_reg || dout.ready);
    assign desc_free = !desc_valid_reg || (step && is_last);

    // blank out leading zeros, the ones digit always shows
    always_comb
    begin
        logic z;
        z = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            z = z & (number_reg[4*i +: 4] == 4'd0);
            zero_above[i] = z;
        end
    end

    always_comb
    begin
        cur_byte = desc_reg.body[body_idx[1:0]];
        if (idx_reg < pfx_len)
        begin
            if (idx_reg == CNT_W'(NUMBER_DIGITS))
                cur_byte = tvef_pkg::CH_TAB;
            else
            begin
                cur_byte = tvef_pkg::CH_SPACE;
                for (int i = 0; i < NUMBER_DIGITS; i++)
                begin
                    if (idx_reg == CNT_W'(NUMBER_DIGITS - 1 - i))
                    begin
                        if (desc_reg.prefix == tvef_pkg::PFX_NUMBER &&
                            !(zero_above[i] && i != 0))
                            cur_byte = {tvef_pkg::DIGIT_HI, number_reg[4*i +: 4]};
                        else
                            cur_byte = tvef_pkg::CH_SPACE;
                    end
                end
            end
        end
    end

    always_comb
    begin
        desc_valid_next = desc_valid_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && dout.ready)
            out_valid_next = 1'b0;
        if (step)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + CNT_W'(1);
            if (is_last)
                desc_valid_next = 1'b0;
        end
        if (load)
        begin
            desc_valid_next = 1'b1;
            idx_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            desc_valid_reg <= desc_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg   <= desc;
            number_reg <= number;
        end
        if (step)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.out_byte    = out_byte_reg;
    assign dout.last_of_run = out_last_reg;

    assign stat.busy      = desc_valid_reg;
    assign stat.step_last = step && is_last;

endmodule

// File: hw/rtl/text_visible_escape_filter.sv
// Top level of the caret-notation text filter: config registers, decode and emit.
//
//  channel | dir | payload                  | handshake
//  --------+-----+--------------------------+------------------------------
//  din     | in  | data_byte[7:0], file_start | valid/ready
//  dout    | out | out_byte[7:0], last_of_run | valid/ready
//  cfg     | in  | cfg_index[2:0], cfg_data   | cfg_we, no back-pressure
//
// Words that map to one character each pass at one word per cycle while dout does not stall.
// A word with a line prefix or an escape holds din ready low while the
// sequencer emits its NUMBER_DIGITS + 5 characters at most, one per cycle unless dout stalls.
// Line state updates when a word is taken; a dropped blank line is taken but emits nothing.
// Characters pass the descriptor register, then the output register. rst_n clears state and config.
// A stall on dout holds the output register, and din too while a descriptor waits.
module text_visible_escape_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tvef_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic                                cfg_data,
    tvef_in_if.sink                             din,
    tvef_out_if.source                          dout
);

    tvef_pkg::cfg_t       cfg_reg, cfg_next;
    tvef_pkg::desc_t      desc;
    tvef_pkg::emit_stat_t stat;
    logic [4*NUMBER_DIGITS-1:0] number;
    logic                 emits;
    logic                 desc_free;
    logic                 accept;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tvef_pkg::cfg_index_t'(cfg_index))
                tvef_pkg::CFG_NUMBER_LINES:  cfg_next.number_lines         = cfg_data;
                tvef_pkg::CFG_NONBLANK_ONLY: cfg_next.number_nonblank_only = cfg_data;
                tvef_pkg::CFG_SHOW_ENDS:     cfg_next.show_ends            = cfg_data;
                tvef_pkg::CFG_SQUEEZE_BLANK: cfg_next.squeeze_blank        = cfg_data;
                tvef_pkg::CFG_SHOW_TABS:     cfg_next.show_tabs            = cfg_data;
                tvef_pkg::CFG_SHOW_NONPRINT: cfg_next.show_nonprinting     = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign din.ready = desc_free;
    assign accept    = din.valid && desc_free;

    tvef_decode #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .data_byte  (din.data_byte),
        .file_start (din.file_start),
        .desc       (desc),
        .number     (number),
        .emits      (emits)
    );

    tvef_emit #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && emits),
        .desc      (desc),
        .number    (number),
        .desc_free (desc_free),
        .stat      (stat),
        .dout      (dout)
    );

    // an idle sequencer always takes a word
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.busy |-> din.ready)
        else $error("din not ready while sequencer idle");

    // a character that is not the last of its word leaves the descriptor busy
    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.last_of_run) |-> stat.busy)
        else $error("partial run without pending descriptor");

    // output register fills only from a busy descriptor
    a_fill_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dout.valid) |-> $past(stat.busy))
        else $error("output filled without descriptor");

    // finishing a descriptor marks the character as last of its word
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        stat.step_last |=> (dout.valid && dout.last_of_run))
        else $error("last_of_run missing on final character");

endmodule
